// File: sv/rfm_pkg.sv
package rfm_pkg;

  localparam int MAX_SIDE = 4096;
  localparam logic [7:0] MASK_FULL = 8'd255;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;

  // squared half-pixel distance, then root with 8 fraction bits
  localparam int D2_W = 31;
  localparam int SQ_W = 48;
  localparam int SQ_ITER = 24;
  localparam int ROOT_W = 24;

  localparam int FRAC_W = 21;
  localparam int NUM_W = 30;
  localparam int DIV_ITER = 9;

  typedef struct packed {
    logic vld;
    logic outside;
  } rfm_tag_t;

endpackage

// File: sv/radial_falloff_mask_top.sv
// radial falloff mask: one pixel coordinate in, one 8-bit mask value out.
// pixel channel: pixel_valid / pixel_stall with pixel_x, pixel_y.
// mask channel: mask_valid / mask_stall with mask_value, outside_region.
// a beat is taken on a clock edge where valid is high and stall is low.
// configuration: cfg_write, cfg_index, cfg_data; write only while no beat
// is in flight. unknown indexes are ignored.
// from pixel beat to mask beat there is one stage for the bounds and
// distances, one for the squares, 24 root stages plus rounding, two for
// the falloff fraction, nine divider stages and the output register.
// throughput is one pixel per cycle while mask_stall holds back no result,
// set by the fully pipelined root and divider.
// when mask_stall holds back a waiting result the whole pipeline freezes
// and pixel_stall rises; while no result waits, the whole pipeline still
// advances and takes beats until a result reaches the output register.
// rst (synchronous) empties the pipeline and loads the default geometry:
// 256 x 256 image, radius 64, falloff 32, no offset.
module radial_falloff_mask_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [11:0]                        pixel_x,
  input  logic [11:0]                        pixel_y,
  output logic                               mask_valid,
  input  logic                               mask_stall,
  output logic [7:0]                         mask_value,
  output logic                               outside_region,
  input  logic                               cfg_write,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rfm_pkg::*;

  logic [12:0]        mask_width;
  logic [12:0]        mask_height;
  logic [11:0]        inner_radius;
  logic [11:0]        falloff_width;
  logic signed [13:0] offset_x;
  logic signed [13:0] offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width <= 13'd256;
      mask_height <= 13'd256;
      inner_radius <= 12'd64;
      falloff_width <= 12'd32;
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MASK_WIDTH:    mask_width <= cfg_data[12:0];
        CFG_MASK_HEIGHT:   mask_height <= cfg_data[12:0];
        CFG_INNER_RADIUS:  inner_radius <= cfg_data[11:0];
        CFG_FALLOFF_WIDTH: falloff_width <= cfg_data[11:0];
        CFG_OFFSET_X:      offset_x <= cfg_data;
        CFG_OFFSET_Y:      offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !(mask_valid && mask_stall);
  assign pixel_stall = !adv;

  // geometry
  logic [12:0]        w_sat;
  logic [12:0]        h_sat;
  logic signed [17:0] cx2;
  logic signed [17:0] cy2;
  logic signed [17:0] t2;
  logic signed [17:0] ax, bx, ay, by;
  logic signed [17:0] bxc, byc;
  logic signed [17:0] lox, hix, loy, hiy;
  logic signed [17:0] px, py;
  logic signed [17:0] dx, dy;
  logic [17:0]        adx, ady;
  logic               outside_c;

  always_comb begin
    w_sat = (mask_width > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : mask_width;
    h_sat = (mask_height > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : mask_height;
    cx2 = $signed({5'b0, w_sat}) - 18'sd1 + 18'($signed({offset_x, 1'b0}));
    cy2 = $signed({5'b0, h_sat}) - 18'sd1 + 18'($signed({offset_y, 1'b0}));
    t2 = $signed({5'b0, inner_radius + {1'b0, falloff_width}} << 1);
    ax = cx2 - t2;
    bx = cx2 + t2;
    ay = cy2 - t2;
    by = cy2 + t2;
    bxc = (bx > $signed({4'b0, w_sat, 1'b0})) ? $signed({4'b0, w_sat, 1'b0}) : bx;
    byc = (by > $signed({4'b0, h_sat, 1'b0})) ? $signed({4'b0, h_sat, 1'b0}) : by;
    lox = (ax < 0) ? 18'sd0 : ((ax + 18'sd1) >>> 1);
    loy = (ay < 0) ? 18'sd0 : ((ay + 18'sd1) >>> 1);
    hix = (bxc <= 0) ? 18'sd0 : ((bxc + 18'sd1) >>> 1);
    hiy = (byc <= 0) ? 18'sd0 : ((byc + 18'sd1) >>> 1);
    px = $signed({6'b0, pixel_x});
    py = $signed({6'b0, pixel_y});
    outside_c = (px < lox) || (px >= hix) || (py < loy) || (py >= hiy)
                || ({1'b0, pixel_x} >= w_sat) || ({1'b0, pixel_y} >= h_sat);
    dx = $signed({5'b0, pixel_x, 1'b0}) - cx2;
    dy = $signed({5'b0, pixel_y, 1'b0}) - cy2;
    adx = (dx < 0) ? 18'(-dx) : 18'(dx);
    ady = (dy < 0) ? 18'(-dy) : 18'(dy);
  end

  rfm_tag_t    s1_tag;
  logic [14:0] s1_hx, s1_hy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else if (adv) begin
      s1_tag <= '{vld: pixel_valid, outside: outside_c};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hx <= adx[14:0] + 15'(w_sat[0]);
      s1_hy <= ady[14:0] + 15'(h_sat[0]);
    end
  end

  rfm_tag_t        s2_tag;
  logic [D2_W-1:0] s2_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else if (adv) begin
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d2 <= D2_W'(s1_hx) * D2_W'(s1_hx) + D2_W'(s1_hy) * D2_W'(s1_hy);
    end
  end

  rfm_tag_t          sq_tag;
  logic [ROOT_W-1:0] sq_root;

  rfm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .tag_in   (s2_tag),
    .rad_in   (s2_d2),
    .tag_out  (sq_tag),
    .root_out (sq_root)
  );

  // falloff fraction
  logic [FRAC_W-1:0] r_fix, f_fix;
  logic [ROOT_W-1:0] over;
  logic [FRAC_W-1:0] e_c;

  always_comb begin
    r_fix = {inner_radius, 9'b0};
    f_fix = {falloff_width, 9'b0};
    over = sq_root - ROOT_W'(r_fix);
    e_c = (over > ROOT_W'(f_fix)) ? f_fix : over[FRAC_W-1:0];
  end

  rfm_tag_t          s3_tag;
  logic              s3_full, s3_zero;
  logic [FRAC_W-1:0] s3_fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
    end else if (adv) begin
      s3_tag <= sq_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_full <= sq_root < ROOT_W'(r_fix);
      s3_zero <= falloff_width == '0;
      s3_fe <= f_fix - e_c;
    end
  end

  rfm_tag_t         s4_tag;
  logic             s4_full, s4_zero;
  logic [NUM_W-1:0] s4_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag <= '0;
    end else if (adv) begin
      s4_tag <= s3_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_full <= s3_full;
      s4_zero <= s3_zero;
      s4_num <= NUM_W'(s3_fe) * NUM_W'({MASK_FULL, 1'b0}) + NUM_W'(f_fix);
    end
  end

  // restoring divider by twice the falloff, one quotient bit per stage
  logic [FRAC_W:0]       dvs;
  assign dvs = {falloff_width, 10'b0};

  rfm_tag_t              dv_tag  [0:DIV_ITER-1];
  logic                  dv_full [0:DIV_ITER-1];
  logic                  dv_zero [0:DIV_ITER-1];
  logic [NUM_W-1:0]      dv_rem  [0:DIV_ITER-1];
  logic [DIV_ITER-1:0]   dv_q    [0:DIV_ITER-1];

  for (genvar j = 0; j < DIV_ITER; j++) begin : g_div
    localparam int K = DIV_ITER - 1 - j;
    rfm_tag_t            tag_i;
    logic                full_i, zero_i;
    logic [NUM_W-1:0]    rem_i;
    logic [DIV_ITER-1:0] q_i;
    logic [NUM_W:0]      dsh;

    if (j == 0) begin : g_first
      assign tag_i = s4_tag;
      assign full_i = s4_full;
      assign zero_i = s4_zero;
      assign rem_i = s4_num;
      assign q_i = '0;
    end else begin : g_rest
      assign tag_i = dv_tag[j-1];
      assign full_i = dv_full[j-1];
      assign zero_i = dv_zero[j-1];
      assign rem_i = dv_rem[j-1];
      assign q_i = dv_q[j-1];
    end

    assign dsh = (NUM_W+1)'(dvs) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_tag[j] <= '0;
      end else if (adv) begin
        dv_tag[j] <= tag_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_full[j] <= full_i;
        dv_zero[j] <= zero_i;
        if ({1'b0, rem_i} >= dsh) begin
          dv_rem[j] <= rem_i - dsh[NUM_W-1:0];
          dv_q[j] <= q_i | (DIV_ITER'(1) << K);
        end else begin
          dv_rem[j] <= rem_i;
          dv_q[j] <= q_i;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= 1'b0;
    end else if (adv) begin
      mask_valid <= dv_tag[DIV_ITER-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outside_region <= dv_tag[DIV_ITER-1].outside;
      if (dv_tag[DIV_ITER-1].outside) begin
        mask_value <= '0;
      end else if (dv_full[DIV_ITER-1]) begin
        mask_value <= MASK_FULL;
      end else if (dv_zero[DIV_ITER-1]) begin
        mask_value <= '0;
      end else begin
        mask_value <= dv_q[DIV_ITER-1][7:0];
      end
    end
  end

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    mask_valid && outside_region |-> mask_value == '0)
    else $error("outside pixel with nonzero mask");

  a_hard_edge: assert property (@(posedge clk) disable iff (rst)
    mask_valid && !outside_region && falloff_width == '0
    |-> mask_value == '0 || mask_value == MASK_FULL)
    else $error("graded value with zero falloff");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sq_tag) && $stable(s4_num))
    else $error("pipeline moved while output held");

endmodule

// File: sv/rfm_isqrt.sv
module rfm_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  rfm_pkg::rfm_tag_t          tag_in,
  input  logic [rfm_pkg::D2_W-1:0]   rad_in,
  output rfm_pkg::rfm_tag_t          tag_out,
  output logic [rfm_pkg::ROOT_W-1:0] root_out
);
  import rfm_pkg::*;

  logic [SQ_W-1:0] rem [0:SQ_ITER-1];
  logic [SQ_W-1:0] res [0:SQ_ITER-1];
  rfm_tag_t        tag [0:SQ_ITER-1];

  for (genvar i = 0; i < SQ_ITER; i++) begin : g_step
    localparam int SH = 2 * (SQ_ITER - 1 - i);
    logic [SQ_W-1:0] rem_in;
    logic [SQ_W-1:0] res_in;
    logic [SQ_W-1:0] trial;
    rfm_tag_t        tag_i;

    if (i == 0) begin : g_first
      assign rem_in = {1'b0, rad_in, 16'b0};
      assign res_in = '0;
      assign tag_i = tag_in;
    end else begin : g_rest
      assign rem_in = rem[i-1];
      assign res_in = res[i-1];
      assign tag_i = tag[i-1];
    end

    assign trial = res_in + (SQ_W'(1) << SH);

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i] <= '0;
      end else if (adv) begin
        tag[i] <= tag_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          rem[i] <= rem_in - trial;
          res[i] <= (res_in >> 1) + (SQ_W'(1) << SH);
        end else begin
          rem[i] <= rem_in;
          res[i] <= res_in >> 1;
        end
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= tag[SQ_ITER-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root_out <= res[SQ_ITER-1][ROOT_W-1:0]
                  + ROOT_W'(rem[SQ_ITER-1] > res[SQ_ITER-1]);
    end
  end

endmodule

// File: verif/radial_falloff_mask_checker.sv
module radial_falloff_mask_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  input  logic                           pixel_stall,
  input  logic [11:0]                    pixel_x,
  input  logic [11:0]                    pixel_y,
  input  logic                           mask_valid,
  input  logic                           mask_stall,
  input  logic [7:0]                     mask_value,
  input  logic                           outside_region,
  input  logic                           cfg_write,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             beats_seen
);
  import rfm_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       outside;
  } mask_beat_t;

  logic [12:0] geo_w, geo_h;
  logic [11:0] geo_r, geo_f;
  logic signed [13:0] geo_ox, geo_oy;
  mask_beat_t mask_queue[$];

  function automatic longint unsigned root_round(longint unsigned n);
    longint unsigned res, bitv, rem;
    res = 0;
    bitv = 64'd1 << 62;
    rem = n;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic longint halve_round(longint v);
    if (v >= 0) return (v + 1) / 2;
    return -((-v + 1) / 2);
  endfunction

  function automatic mask_beat_t mask_of(logic [11:0] x, logic [11:0] y);
    longint px, py, w, h, cx2, cy2, t, a, b, x0, x1, y0, y1, hx, hy;
    longint unsigned d2, s, r, f, e, num;
    mask_beat_t o;
    px = x;
    py = y;
    w = (geo_w > MAX_SIDE) ? MAX_SIDE : geo_w;
    h = (geo_h > MAX_SIDE) ? MAX_SIDE : geo_h;
    cx2 = (w - 1) + 2 * longint'(geo_ox);
    cy2 = (h - 1) + 2 * longint'(geo_oy);
    t = longint'(geo_r) + longint'(geo_f);
    a = cx2 - 2 * t; b = cx2 + 2 * t;
    if (a < 0) a = 0;
    if (b > 2 * w) b = 2 * w;
    x0 = halve_round(a); x1 = halve_round(b);
    a = cy2 - 2 * t; b = cy2 + 2 * t;
    if (a < 0) a = 0;
    if (b > 2 * h) b = 2 * h;
    y0 = halve_round(a); y1 = halve_round(b);
    o.value = 0;
    o.outside = 1;
    if (px < x0 || px >= x1 || py < y0 || py >= y1 || px >= w || py >= h) return o;
    hx = 2 * px - cx2;
    if (hx < 0) hx = -hx;
    hx += w & 1;
    hy = 2 * py - cy2;
    if (hy < 0) hy = -hy;
    hy += h & 1;
    d2 = hx * hx + hy * hy;
    s = root_round(d2 << 16);
    r = longint'(geo_r) << 9;
    f = longint'(geo_f) << 9;
    o.outside = 0;
    if (s < r) o.value = MASK_FULL;
    else if (f == 0) o.value = 0;
    else begin
      e = s - r;
      if (e > f) e = f;
      num = 255 * (f - e);
      o.value = 8'((2 * num + f) / (2 * f));
    end
    return o;
  endfunction

  assign pending = mask_queue.size();

  always @(posedge clk) begin
    mask_beat_t want;
    if (rst) begin
      geo_w <= 13'd256; geo_h <= 13'd256;
      geo_r <= 12'd64;  geo_f <= 12'd32;
      geo_ox <= '0;     geo_oy <= '0;
      fail_count <= 0;
      beats_seen <= 0;
      mask_queue.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MASK_WIDTH:    geo_w <= cfg_data[12:0];
          CFG_MASK_HEIGHT:   geo_h <= cfg_data[12:0];
          CFG_INNER_RADIUS:  geo_r <= cfg_data[11:0];
          CFG_FALLOFF_WIDTH: geo_f <= cfg_data[11:0];
          CFG_OFFSET_X:      geo_ox <= cfg_data;
          CFG_OFFSET_Y:      geo_oy <= cfg_data;
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) mask_queue = {mask_queue, mask_of(pixel_x, pixel_y)};
      if (mask_valid && !mask_stall) begin
        beats_seen <= beats_seen + 1;
        if (mask_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected mask beat %0d/%0b", mask_value,
                                        outside_region);
          fail_count <= fail_count + 1;
        end else begin
          want = mask_queue.pop_front();
          if (want.value !== mask_value || want.outside !== outside_region) begin
            if (fail_count < 10)
              $display("mask mismatch: expected %0d/%0b got %0d/%0b", want.value,
                       want.outside, mask_value, outside_region);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/radial_falloff_mask_top_tb.sv
module radial_falloff_mask_top_tb;
  import rfm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic clk = 0, rst = 1;
  logic pixel_valid = 0, mask_stall = 0, cfg_write = 0;
  logic [11:0] pixel_x = 0, pixel_y = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic pixel_stall, mask_valid, outside_region;
  logic [7:0] mask_value;
  int fail_count, pending, beats_seen, cycles = 0, sent = 0;
  bit calm = 0, hold_long = 0;

  always #2 clk = ~clk;

  radial_falloff_mask_top i_dut (.*);
  radial_falloff_mask_checker i_check (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout");
      $display("radial_falloff_mask_top_tb NOT OK");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        mask_stall <= 1;
        repeat (150) @(negedge clk);
        mask_stall <= 0;
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        mask_stall <= 1;
        repeat (n - 1) @(negedge clk);
      end else begin
        mask_stall <= 0;
      end
    end
  end

  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pixel_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    pixel_valid <= 1;
    pixel_x <= x;
    pixel_y <= y;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    pixel_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic set_geometry(int w, int h, int r, int f, int ox, int oy);
    set_reg(CFG_MASK_WIDTH, 14'(w));
    set_reg(CFG_MASK_HEIGHT, 14'(h));
    set_reg(CFG_INNER_RADIUS, 14'(r));
    set_reg(CFG_FALLOFF_WIDTH, 14'(f));
    set_reg(CFG_OFFSET_X, 14'(ox));
    set_reg(CFG_OFFSET_Y, 14'(oy));
  endtask

  task automatic random_phase(int n, int w, int h, int span);
    int xs, ys;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        xs = $urandom_range(0, 4095);
        ys = $urandom_range(0, 4095);
      end else begin
        xs = (w / 2 + $urandom_range(0, 2 * span) - span) & 12'hfff;
        ys = (h / 2 + $urandom_range(0, 2 * span) - span) & 12'hfff;
      end
      send_pixel(xs[11:0], ys[11:0]);
      if (i == n / 2 && !calm && $urandom_range(0, 3) == 0) hold_long = 1;
    end
    drain();
  endtask

  initial begin
    int w, h, r, f;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed beats on the reset geometry
    send_pixel(12'd128, 12'd128);
    send_pixel(12'd127, 12'd127);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd128, 12'd40);
    send_pixel(12'd128, 12'd32);
    send_pixel(12'd128, 12'd31);
    send_pixel(12'd128, 12'd224);
    send_pixel(12'd210, 12'd128);
    drain();
    set_reg(CFG_SPARE, 14'h3fff);
    set_geometry(4096, 4096, 4095, 4095, 4096, -4096);
    send_pixel(12'hfff, 12'd0);
    send_pixel(12'd0, 12'hfff);
    send_pixel(12'h800, 12'h800);
    drain();
    set_geometry(8191, 5, 10, 0, 0, 0);
    send_pixel(12'd2048, 12'd2);
    send_pixel(12'd2050, 12'd2);
    send_pixel(12'd2060, 12'd0);
    drain();
    set_geometry(0, 1, 0, 0, 8191, 8192);
    send_pixel(12'd0, 12'd0);
    drain();
    set_geometry(1, 1, 0, 1, 0, 0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain();
    hold_long = 1;
    set_geometry(301, 199, 40, 25, -7, 13);
    random_phase(300, 301, 199, 90);
    for (int p = 0; p < 8; p++) begin
      w = $urandom_range(1, 600);
      h = $urandom_range(1, 600);
      r = $urandom_range(0, 200);
      f = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
      set_geometry(w, h, r, f, $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
      random_phase(120, w, h, r + f + 20);
    end
    set_geometry(4096, 4096, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096);
    random_phase(150, 4096, 4096, 2047);
    calm = 1;
    set_geometry(640, 480, 100, 60, 20, -10);
    random_phase(150, 640, 480, 200);
    $display("checked %0d mask beats over %0d geometries incl. extremes", beats_seen, 16);
    if (fail_count == 0) $display("radial_falloff_mask_top_tb OK");
    else $display("radial_falloff_mask_top_tb NOT OK");
    $finish;
  end
endmodule

// File: radial_falloff_mask_top.f
sv/rfm_pkg.sv
sv/rfm_isqrt.sv
sv/radial_falloff_mask_top.sv
verif/radial_falloff_mask_checker.sv
verif/radial_falloff_mask_top_tb.sv
